// ===== src/rmcsfe_pkg.sv =====
// Shared types and constants for the RMC sentence field extractor.
// No dependencies; used by rmcsfe_parser and the top level.
`default_nettype none

package rmcsfe_pkg;

	// Field identifiers carried with every extracted character
	localparam logic [2:0] FID_TIME  = 3'd0;
	localparam logic [2:0] FID_LAT   = 3'd1;
	localparam logic [2:0] FID_LON   = 3'd2;
	localparam logic [2:0] FID_SPEED = 3'd3;
	localparam logic [2:0] FID_DATE  = 3'd4;

	// ASCII codes
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_N      = 8'h4E;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	// "$GN" as the last three bytes before the 'R'
	localparam logic [23:0] HDR_PREFIX = {CH_DOLLAR, CH_G, CH_N};

	// Byte offsets from the '$'
	localparam logic [6:0] OFF_HDR_END   = 7'd3;
	localparam logic [6:0] OFF_TIME      = 7'd7;
	localparam logic [6:0] OFF_TIME_END  = 7'd15;
	localparam logic [6:0] OFF_LAT       = 7'd19;
	localparam logic [6:0] OFF_LAT_END   = 7'd28;
	localparam logic [6:0] OFF_LON       = 7'd32;
	localparam logic [6:0] OFF_LON_END   = 7'd42;
	localparam logic [6:0] OFF_SPEED_GO  = 7'd45;

	localparam logic [2:0] DATE_LAST = 3'd5;

	typedef struct packed {
		logic [2:0] field_id;
		logic [3:0] char_index;
		logic [7:0] char_value;
		logic       speed_truncated;
		logic       frame_done;
	} rmc_result_t;

endpackage

`default_nettype wire

// ===== src/rmcsfe_parser.sv =====
// Sentence parser: header hunt, offset counting and field character selection.
// Depends on rmcsfe_pkg.
`default_nettype none

module rmcsfe_parser #(
	parameter int SPEED_CHARS = 7
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      accept,
	input  wire logic [7:0]                rx_byte,
	input  wire logic                      restart,
	output logic                           res_valid,
	output rmcsfe_pkg::rmc_result_t        res
);

	localparam int SLW = $clog2(SPEED_CHARS + 1);

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_FIXED = 3'd1,
		PH_SPEED = 3'd2,
		PH_SKIP  = 3'd3,
		PH_DATE  = 3'd4
	} phase_t;

	logic [23:0]    hist_q, hist_c, hist_d;
	phase_t         phase_q, phase_c, phase_d;
	logic [5:0]     off_q, off_c, off_d;
	logic [SLW-1:0] slen_q, slen_c, slen_d;
	logic [2:0]     dlen_q, dlen_c, dlen_d;
	logic           ovf_q, ovf_c, ovf_d;
	logic [6:0]     off_n;

	always_comb begin
		// restart applies the reset state before this byte is handled
		hist_c  = restart ? '0 : hist_q;
		phase_c = restart ? PH_HUNT : phase_q;
		off_c   = restart ? '0 : off_q;
		slen_c  = restart ? '0 : slen_q;
		dlen_c  = restart ? '0 : dlen_q;
		ovf_c   = restart ? 1'b0 : ovf_q;

		hist_d  = hist_c;
		phase_d = phase_c;
		off_d   = off_c;
		slen_d  = slen_c;
		dlen_d  = dlen_c;
		ovf_d   = ovf_c;
		off_n   = {1'b0, off_c} + 7'd1;

		res_valid           = 1'b0;
		res.field_id        = rmcsfe_pkg::FID_TIME;
		res.char_index      = '0;
		res.char_value      = rx_byte;
		res.speed_truncated = ovf_c;
		res.frame_done      = 1'b0;

		unique case (phase_c)
			PH_FIXED: begin
				off_d = off_n[5:0];
				if (off_n >= rmcsfe_pkg::OFF_SPEED_GO)
					phase_d = PH_SPEED;
				if (off_n >= rmcsfe_pkg::OFF_TIME && off_n <= rmcsfe_pkg::OFF_TIME_END) begin
					res_valid      = 1'b1;
					res.field_id   = rmcsfe_pkg::FID_TIME;
					res.char_index = 4'(off_n - rmcsfe_pkg::OFF_TIME);
				end else if (off_n >= rmcsfe_pkg::OFF_LAT &&
				             off_n <= rmcsfe_pkg::OFF_LAT_END) begin
					res_valid      = 1'b1;
					res.field_id   = rmcsfe_pkg::FID_LAT;
					res.char_index = 4'(off_n - rmcsfe_pkg::OFF_LAT);
				end else if (off_n >= rmcsfe_pkg::OFF_LON &&
				             off_n <= rmcsfe_pkg::OFF_LON_END) begin
					res_valid      = 1'b1;
					res.field_id   = rmcsfe_pkg::FID_LON;
					res.char_index = 4'(off_n - rmcsfe_pkg::OFF_LON);
				end
			end
			PH_SPEED: begin
				if (rx_byte == rmcsfe_pkg::CH_COMMA) begin
					phase_d = PH_SKIP;
				end else if (32'(slen_c) < SPEED_CHARS) begin
					res_valid      = 1'b1;
					res.field_id   = rmcsfe_pkg::FID_SPEED;
					res.char_index = 4'(slen_c);
					slen_d         = slen_c + 1'b1;
				end else begin
					ovf_d = 1'b1;
				end
			end
			PH_SKIP: begin
				if (rx_byte == rmcsfe_pkg::CH_COMMA) begin
					phase_d = PH_DATE;
					dlen_d  = '0;
				end
			end
			PH_DATE: begin
				res_valid      = 1'b1;
				res.field_id   = rmcsfe_pkg::FID_DATE;
				if (dlen_c >= rmcsfe_pkg::DATE_LAST) begin
					res.char_index = 4'(rmcsfe_pkg::DATE_LAST);
					res.frame_done = 1'b1;
					phase_d        = PH_HUNT;
					dlen_d         = '0;
					hist_d         = '0;
				end else begin
					res.char_index = {1'b0, dlen_c};
					dlen_d         = dlen_c + 3'd1;
				end
			end
			default: begin
				// hunting; stray phase codes land here too
				if (hist_c == rmcsfe_pkg::HDR_PREFIX && rx_byte == rmcsfe_pkg::CH_R) begin
					hist_d  = '0;
					phase_d = PH_FIXED;
					off_d   = rmcsfe_pkg::OFF_HDR_END[5:0];
					slen_d  = '0;
					dlen_d  = '0;
					ovf_d   = 1'b0;
				end else begin
					phase_d = PH_HUNT;
					hist_d  = {hist_c[15:0], rx_byte};
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			phase_q <= PH_HUNT;
			off_q   <= '0;
			slen_q  <= '0;
			dlen_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			hist_q  <= hist_d;
			phase_q <= phase_d;
			off_q   <= off_d;
			slen_q  <= slen_d;
			dlen_q  <= dlen_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/rmc_sentence_field_extractor_top.sv =====
// A result reaches the master side through the result register, or through the skid and then the result register.
// Throughput: one byte per cycle while the skid is empty; the parser state updates in a single pass.
// A two-entry output stage (result register plus skid) lets bytes keep flowing
// while one result waits; s_tready drops only once a second result sits in the skid.
// Reset (arst_n low, asynchronous): parser hunts for "$GNR", output stage empty.
`default_nettype none

module rmc_sentence_field_extractor_top #(
	parameter int SPEED_CHARS = 7
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// slave side: received bytes
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic        s_tuser,   // [0] restart

	// master side: extracted characters
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [2:0] field_id, [6:3] char_index,
	                                    // [14:7] char_value, [15] zero
	output logic             m_tuser,   // [0] speed_truncated
	output logic             m_tlast    // frame_done
);

	logic                    in_fire;
	logic                    out_fire;
	logic                    res_valid;
	rmcsfe_pkg::rmc_result_t res;

	logic                    out_valid_q;
	rmcsfe_pkg::rmc_result_t out_q;
	logic                    skid_valid_q;
	rmcsfe_pkg::rmc_result_t skid_q;

	// A new request is taken whenever the skid slot is free.
	assign s_tready = !skid_valid_q;
	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = out_valid_q && m_tready;

	rmcsfe_parser #(
		.SPEED_CHARS(SPEED_CHARS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_fire),
		.rx_byte   (s_tdata),
		.restart   (s_tuser),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output stage. The skid only fills when the result register is held and a
	// new result arrives; it drains first, ahead of anything new.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || out_fire) begin
			out_valid_q <= in_fire && res_valid;
		end else if (in_fire && res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire)
				out_q <= skid_q;
		end else if (!out_valid_q || out_fire) begin
			out_q <= res;
		end else begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.char_value, out_q.char_index, out_q.field_id};
	assign m_tuser  = out_q.speed_truncated;
	assign m_tlast  = out_q.frame_done;

	// Skid holds data only behind a full result register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid full while result register empty");

	// End of frame is always the sixth date character.
	a_done_is_last_date: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |->
		(out_q.field_id == rmcsfe_pkg::FID_DATE &&
		 out_q.char_index == 4'(rmcsfe_pkg::DATE_LAST)))
		else $error("frame_done on a non-final character");

	// Speed characters never index past the configured capacity.
	a_speed_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.field_id == rmcsfe_pkg::FID_SPEED) |->
		(32'(out_q.char_index) < SPEED_CHARS))
		else $error("speed character index beyond capacity");

	// A byte that yields a result is never dropped: the skid is free when it comes.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && res_valid && out_valid_q && !out_fire) |=> skid_valid_q)
		else $error("result lost in output stage");

endmodule

`default_nettype wire
